// ===== rtl/core/mexp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mexp_pkg;

    localparam int KEY_BITS_DEF = 128;
    localparam int HALF_W       = 64;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MOD_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOD_LOWER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_UPPER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LOWER = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_REDUCE,
        S_WAIT_REDUCE,
        S_MUL_RES,
        S_WAIT_RES,
        S_MUL_BASE,
        S_WAIT_BASE,
        S_FINAL,
        S_WAIT_FINAL,
        S_OUT
    } t_state;

    // Handshake from sequencer to the multiplier.
    typedef struct packed {
        logic start;
    } t_mul_ctrl;

    typedef struct packed {
        logic done;
    } t_mul_stat;

endpackage
`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Bit-serial modular multiplier: r = (a * b) mod n by interleaved
// shift-add-subtract, one bit of a per cycle, most significant first.
// Equals the remainder of the full product since the remainder of
// 2r + a_i*b is computed exactly each step. Operand b must be at most n;
// operand a may take any value.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int W = KEY_BITS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_mul_ctrl  i_ctrl,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    input  wire logic [W-1:0] i_n,
    output t_mul_stat       o_stat,
    output logic [W-1:0]    o_r
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_a, n_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_r, n_r;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_done, n_done;

    logic [W+1:0] w_dbl, w_add, w_s1;

    // One step: r = 2r mod n, then add b if bit set, reduce again.
    always_comb begin
        w_dbl = {1'b0, r_r, 1'b0};
        if (w_dbl >= {2'b00, i_n}) begin
            w_dbl = w_dbl - {2'b00, i_n};
        end
        w_add = w_dbl + (r_a[W-1] ? {2'b00, r_b} : '0);
        w_s1 = w_add;
        if (w_s1 >= {2'b00, i_n}) begin
            w_s1 = w_s1 - {2'b00, i_n};
        end
    end

    // Step counter and operand shift.
    always_comb begin
        n_a    = r_a;
        n_r    = r_r;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_ctrl.start) begin
            n_a    = i_a;
            n_r    = '0;
            n_cnt  = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_a   = {r_a[W-2:0], 1'b0};
            n_r   = w_s1[W-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a <= n_a;
        r_r <= n_r;
        if (i_ctrl.start) begin
            r_b <= i_b;
        end
    end

    assign o_stat.done = r_done;
    assign o_r         = r_r;
endmodule
`default_nettype wire

// ===== rtl/core/modular_exponentiation_128_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Direction | Handshake         | Payload
// input    | in        | i_valid / o_stall | i_ciphertext_upper, i_ciphertext_lower
// output   | out       | o_valid / i_stall | o_plaintext_upper/lower, o_bad_modulus
// config   | in        | i_cfg_we          | i_cfg_index, i_cfg_data
// An item takes up to 2*KEY_BITS+2 modular products, computed one at a time
// by the single bit-serial multiplier.
// A zero modulus gives its result in the cycle after the beat.
// Reset is synchronous and active low; it clears the key registers, the error flag and the sequencer.
// The result waits in the output register while i_stall is high.
module modular_exponentiation_128_top
    import mexp_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [HALF_W-1:0]    i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [HALF_W-1:0]    i_ciphertext_upper,
    input  wire logic [HALF_W-1:0]    i_ciphertext_lower,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [HALF_W-1:0]         o_plaintext_upper,
    output logic [HALF_W-1:0]         o_plaintext_lower,
    output logic                      o_bad_modulus
);
    localparam int BW = $clog2(KEY_BITS + 1);

    logic [HALF_W-1:0] r_mod_hi, r_mod_lo, r_exp_hi, r_exp_lo;
    t_state            r_state, n_state;
    logic [KEY_BITS-1:0] r_base, r_res;
    logic [BW-1:0]     r_bit, n_bit;
    logic              r_bad;
    t_mul_ctrl         w_ctrl;
    t_mul_stat         w_stat;
    logic [KEY_BITS-1:0] w_a, w_b, w_r;
    logic [KEY_BITS-1:0] w_exp;
    logic              w_mod_zero;

    assign w_exp      = {r_exp_hi, r_exp_lo};
    assign w_mod_zero = (r_mod_hi == '0) && (r_mod_lo == '0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_hi <= '0;
            r_mod_lo <= '0;
            r_exp_hi <= '0;
            r_exp_lo <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MOD_UPPER: r_mod_hi <= i_cfg_data;
                REG_MOD_LOWER: r_mod_lo <= i_cfg_data;
                REG_EXP_UPPER: r_exp_hi <= i_cfg_data;
                REG_EXP_LOWER: r_exp_lo <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_bit   = '0;
                    n_state = w_mod_zero ? S_OUT : S_REDUCE;
                end
            end
            S_REDUCE:      n_state = S_WAIT_REDUCE;
            S_WAIT_REDUCE: if (w_stat.done) n_state = S_MUL_RES;
            S_MUL_RES: begin
                if (r_bit == BW'(KEY_BITS)) begin
                    n_state = S_FINAL;
                end else if (w_exp[r_bit[BW-2:0]]) begin
                    n_state = S_WAIT_RES;
                end else begin
                    n_state = S_MUL_BASE;
                end
            end
            S_WAIT_RES:   if (w_stat.done) n_state = S_MUL_BASE;
            S_MUL_BASE:   n_state = S_WAIT_BASE;
            S_WAIT_BASE: begin
                if (w_stat.done) begin
                    n_bit   = r_bit + 1'b1;
                    n_state = S_MUL_RES;
                end
            end
            S_FINAL:      n_state = S_WAIT_FINAL;
            S_WAIT_FINAL: if (w_stat.done) n_state = S_OUT;
            S_OUT:        if (!i_stall) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Multiplier operand selection and start. The ciphertext is first reduced
    // by a product with one, so the multiplicand is never above the modulus.
    always_comb begin
        w_ctrl.start = 1'b0;
        w_a = r_res;
        w_b = r_base;
        case (r_state)
            S_REDUCE: begin
                w_ctrl.start = 1'b1;
                w_a = r_base;
                w_b = KEY_BITS'(1);
            end
            S_MUL_RES: w_ctrl.start = (r_bit != BW'(KEY_BITS)) && w_exp[r_bit[BW-2:0]];
            S_MUL_BASE: begin
                w_ctrl.start = 1'b1;
                w_a = r_base;
            end
            S_FINAL: begin
                w_ctrl.start = 1'b1;
                w_b = KEY_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
            if (r_state == S_IDLE && i_valid) begin
                r_bad <= w_mod_zero;
            end
        end
        if (r_state == S_IDLE && i_valid) begin
            r_base <= {i_ciphertext_upper, i_ciphertext_lower};
            r_res  <= w_mod_zero ? '0 : KEY_BITS'(1);
        end else if (w_stat.done) begin
            if (r_state inside {S_WAIT_BASE, S_WAIT_REDUCE}) begin
                r_base <= w_r;
            end else begin
                r_res <= w_r;
            end
        end
    end

    mexp_mulmod #(.W(KEY_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_n     ({r_mod_hi, r_mod_lo}),
        .o_stat  (w_stat),
        .o_r     (w_r)
    );

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = (r_state == S_OUT);
    assign o_plaintext_upper = r_res[2*HALF_W-1:HALF_W];
    assign o_plaintext_lower = r_res[HALF_W-1:0];
    assign o_bad_modulus     = r_bad;
endmodule
`default_nettype wire

// ===== rtl/core/mexp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks on the exponentiation block.
module mexp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [63:0] o_plaintext_upper,
    input wire logic [63:0] o_plaintext_lower,
    input wire logic        o_bad_modulus
);
    // A beat in never coincides with a pending result.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("result shown while block is ready");

    // An accepted beat makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall) else $error("not busy after beat");

    // A bad-modulus result is zero.
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_modulus) |-> (o_plaintext_upper == '0 && o_plaintext_lower == '0))
        else $error("bad modulus with nonzero result");

    // A stalled result stays valid and its lower half holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_plaintext_lower)))
        else $error("stalled result changed");
endmodule

bind modular_exponentiation_128_top mexp_checker u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_stall           (o_stall),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_plaintext_upper (o_plaintext_upper),
    .o_plaintext_lower (o_plaintext_lower),
    .o_bad_modulus     (o_bad_modulus)
);
`default_nettype wire

// ===== tb/sv/modular_exponentiation_128_top_test.sv =====
`timescale 1ns / 1ps
module modular_exponentiation_128_top_test;
    import mexp_pkg::*;

    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int     TAIL_CYCLES = 40;

    // A fixed key pair used for one of the directed phases.
    localparam logic [127:0] KEY_MODULUS  = 128'hBF238AC4_7A2B85E8_7A0495B3_36F349F4;
    localparam logic [127:0] KEY_EXPONENT = 128'h8932ABA7_5549986C_ED803869_5DFE89B5;

    typedef struct {
        logic [HALF_W-1:0] upper;
        logic [HALF_W-1:0] lower;
        logic              bad;
    } t_plain;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [HALF_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [HALF_W-1:0]    i_ciphertext_upper;
    logic [HALF_W-1:0]    i_ciphertext_lower;
    logic                 o_valid;
    logic                 i_stall;
    logic [HALF_W-1:0]    o_plaintext_upper;
    logic [HALF_W-1:0]    o_plaintext_lower;
    logic                 o_bad_modulus;

    // Local copy of the key registers.
    logic [127:0] key_n;
    logic [127:0] key_d;

    t_plain  plain_q[$];
    int      error_count;
    int      beats_sent;
    int      beats_checked;
    longint  cycle_count;
    int      stall_left;
    bit      no_idle;

    modular_exponentiation_128_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_ciphertext_upper (i_ciphertext_upper),
        .i_ciphertext_lower (i_ciphertext_lower),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_plaintext_upper  (o_plaintext_upper),
        .o_plaintext_lower  (o_plaintext_lower),
        .o_bad_modulus      (o_bad_modulus)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results pending", $time, plain_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Right-to-left square and multiply, each product fully reduced.
    function automatic t_plain power_mod(logic [127:0] c);
        logic [255:0] acc;
        logic [255:0] base;
        logic [255:0] m;
        t_plain       res;
        m    = {128'b0, key_n};
        acc  = 256'd1;
        base = {128'b0, c};
        if (key_n == 128'b0) begin
            res.upper = '0;
            res.lower = '0;
            res.bad   = 1'b1;
            return res;
        end
        for (int i = 0; i < 128; i++) begin
            if (key_d[i]) acc = (acc * base) % m;
            base = (base * base) % m;
        end
        acc       = acc % m;
        res.upper = acc[127:64];
        res.lower = acc[63:0];
        res.bad   = 1'b0;
        return res;
    endfunction

    // Receiver stall: redrawn after every accepted result.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        t_plain want;
        if (i_rst_n && o_valid && !i_stall) begin
            stall_left = no_idle ? 0 : $urandom_range(0, 11);
            beats_checked++;
            if (plain_q.size() == 0) begin
                $display("%0t: unexpected result beat, actual %h_%h bad %b", $time,
                         o_plaintext_upper, o_plaintext_lower, o_bad_modulus);
                error_count++;
            end else begin
                want = plain_q.pop_front();
                if (o_plaintext_upper !== want.upper) begin
                    $display("%0t: plaintext_upper expected %h actual %h", $time,
                             want.upper, o_plaintext_upper);
                    error_count++;
                end
                if (o_plaintext_lower !== want.lower) begin
                    $display("%0t: plaintext_lower expected %h actual %h", $time,
                             want.lower, o_plaintext_lower);
                    error_count++;
                end
                if (o_bad_modulus !== want.bad) begin
                    $display("%0t: bad_modulus expected %b actual %b", $time,
                             want.bad, o_bad_modulus);
                    error_count++;
                end
            end
        end
    end

    // Writes one key register; called only while the block is idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [HALF_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_MOD_UPPER: key_n[127:64] = value;
            REG_MOD_LOWER: key_n[63:0]   = value;
            REG_EXP_UPPER: key_d[127:64] = value;
            default:       key_d[63:0]   = value;
        endcase
    endtask

    task automatic load_key(logic [127:0] n, logic [127:0] d);
        write_reg(REG_MOD_UPPER, n[127:64]);
        write_reg(REG_MOD_LOWER, n[63:0]);
        write_reg(REG_EXP_UPPER, d[127:64]);
        write_reg(REG_EXP_LOWER, d[63:0]);
    endtask

    // Sends one ciphertext beat; entered and left at a falling edge.
    task automatic send_cipher(logic [127:0] c);
        int     gap;
        t_plain want;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        want = power_mod(c);
        i_valid            <= 1'b1;
        i_ciphertext_upper <= c[127:64];
        i_ciphertext_lower <= c[63:0];
        do @(posedge i_clk); while (o_stall);
        plain_q.push_back(want);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Lowers valid and waits until every expected result has arrived.
    task automatic drain;
        i_valid <= 1'b0;
        while (plain_q.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Zero modulus, including the reset state, gives the error flag.
    task automatic test_zero_modulus;
        send_cipher(128'd5);
        send_cipher('1);
        drain();
        load_key(128'b0, '1);
        send_cipher(128'b0);
        send_cipher(rand128());
        drain();
    endtask

    // Fixed key pair with edge ciphertexts and one at or above the modulus.
    task automatic test_fixed_key;
        load_key(KEY_MODULUS, KEY_EXPONENT);
        send_cipher(128'b0);
        send_cipher(128'd1);
        send_cipher(KEY_MODULUS);
        send_cipher('1);
        drain();
    endtask

    // Extreme moduli and exponents, back to back with no idling.
    task automatic test_extremes;
        no_idle = 1'b1;
        load_key(128'd1, 128'b0);
        send_cipher(128'd7);
        drain();
        load_key('1, 128'b0);
        send_cipher('1);
        send_cipher(128'd3);
        drain();
        load_key('1, '1);
        send_cipher({64'b0, 64'hFFFF_FFFF_FFFF_FFFF});
        send_cipher({64'hFFFF_FFFF_FFFF_FFFF, 64'b0});
        drain();
        load_key(128'd2, 128'd1);
        send_cipher(128'd3);
        drain();
        load_key({64'h1, 64'h0}, 128'd2);
        send_cipher({64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
        drain();
        no_idle = 1'b0;
    endtask

    // Random keys and ciphertexts; small moduli and the zero modulus now and then.
    task automatic test_random;
        logic [127:0] n;
        for (int k = 0; k < 10; k++) begin
            case ($urandom_range(0, 5))
                0:       n = 128'b0;
                1:       n = {96'b0, 32'($urandom_range(1, 1000))};
                default: n = rand128();
            endcase
            load_key(n, rand128());
            no_idle = (k == 3);
            for (int j = 0; j < 8; j++) send_cipher(rand128());
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = '0;
        i_cfg_data         = '0;
        i_valid            = 1'b0;
        i_ciphertext_upper = '0;
        i_ciphertext_lower = '0;
        i_stall            = 1'b0;
        key_n              = '0;
        key_d              = '0;
        error_count        = 0;
        beats_sent         = 0;
        beats_checked      = 0;
        cycle_count        = 0;
        stall_left         = 0;
        no_idle            = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_zero_modulus();
        test_fixed_key();
        test_extremes();
        test_random();

        $display("Sent %0d ciphertext beats and checked %0d results over %0d cycles,",
                 beats_sent, beats_checked, cycle_count);
        $display("covering zero, unit, full-width and random keys with random stalls.");
        if (error_count == 0 && plain_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== modular_exponentiation_128_top.f =====
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_128_top.sv
rtl/core/mexp_checker.sv
tb/sv/modular_exponentiation_128_top_test.sv
